@@ rtl/lifo_stack_with_search_macros.svh @@
// Assertion macros for the LIFO stack checker.
// Expects clk and arst_n in the scope of use.
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define LSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lss_pkg.sv @@
// Shared types and constants for the LIFO stack with search.
// No dependencies.
`default_nettype none

package lss_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int VAL_W = 32;
	localparam int CNT_W = 7;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_PEEK   = 2'd2;
	localparam logic [1:0] OP_SEARCH = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [VAL_W-1:0] top_value;
		logic [1:0]              status;
		logic                    found;
		logic [CNT_W-1:0]        depth_now;
		logic [CNT_W-1:0]        even_count;
		logic [CNT_W-1:0]        odd_count;
		logic                    is_empty;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/lss_if.sv @@
// Valid/ready channel interfaces for command and result beats.
// Depends on lss_pkg.
`default_nettype none

interface lss_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      op;
	logic signed [lss_pkg::VAL_W-1:0] value;

	modport source (output valid, op, value, input ready);
	modport sink (input valid, op, value, output ready);
endinterface

interface lss_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [lss_pkg::VAL_W-1:0] top_value;
	logic [1:0]                       status;
	logic                             found;
	logic [lss_pkg::CNT_W-1:0]        depth_now;
	logic [lss_pkg::CNT_W-1:0]        even_count;
	logic [lss_pkg::CNT_W-1:0]        odd_count;
	logic                             is_empty;

	modport source (output valid, top_value, status, found, depth_now, even_count,
		odd_count, is_empty, input ready);
	modport sink (input valid, top_value, status, found, depth_now, even_count,
		odd_count, is_empty, output ready);
endinterface

`default_nettype wire

@@ rtl/lss_mem.sv @@
// Entry store: one write port, one read port, registered read data.
// Depends on lss_pkg.
`default_nettype none

module lss_mem #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [lss_pkg::VAL_W-1:0]  wdata,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              raddr,
	output      logic [lss_pkg::VAL_W-1:0]  rdata
);

	logic [lss_pkg::VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/lss_ctrl.sv @@
// Sequencer: push/pop/peek/search against the entry store, depth and parity counts.
// Depends on lss_pkg.
`default_nettype none

module lss_ctrl #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic [1:0]                        op,
	input  wire logic signed [lss_pkg::VAL_W-1:0]  value,
	output      logic                              idle,
	output      logic                              res_valid,
	output      lss_pkg::res_t                     res,
	output      logic                              mem_we,
	output      logic [AW-1:0]                     mem_waddr,
	output      logic [lss_pkg::VAL_W-1:0]         mem_wdata,
	output      logic                              mem_re,
	output      logic [AW-1:0]                     mem_raddr,
	input  wire logic [lss_pkg::VAL_W-1:0]         mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t                    state_q, state_d;
	logic [CW-1:0]             count_q, count_d;
	logic [CW-1:0]             even_q, even_d;
	logic [lss_pkg::VAL_W-1:0] key_q, key_d;
	logic [AW-1:0]             addr_q, addr_d;
	logic                      last_q, last_d;
	logic                      pop_q, pop_d;
	logic                      match;
	logic signed [lss_pkg::VAL_W-1:0] r_top;
	logic [1:0]                r_status;
	logic                      r_found;

	assign idle  = (state_q == S_IDLE);
	assign match = (mem_rdata == key_q);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		even_d    = even_q;
		key_d     = key_q;
		addr_d    = addr_q;
		last_d    = last_q;
		pop_d     = pop_q;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = value;
		mem_re    = 1'b0;
		mem_raddr = '0;
		res_valid = 1'b0;
		r_top     = '0;
		r_status  = lss_pkg::ST_OK;
		r_found   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						lss_pkg::OP_PUSH: begin
							res_valid = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								r_status = lss_pkg::ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CW'(1);
								if (!value[0]) begin
									even_d = even_q + CW'(1);
								end
							end
						end
						lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
							if (count_q == '0) begin
								res_valid = 1'b1;
								r_status  = lss_pkg::ST_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(count_q - CW'(1));
								pop_d     = (op == lss_pkg::OP_POP);
								state_d   = S_READ;
							end
						end
						lss_pkg::OP_SEARCH: begin
							if (count_q == '0) begin
								res_valid = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								addr_d    = AW'(1);
								last_d    = (count_q == CW'(1));
								key_d     = value;
								state_d   = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				res_valid = 1'b1;
				r_top     = mem_rdata;
				state_d   = S_IDLE;
				if (pop_q) begin
					count_d = count_q - CW'(1);
					if (!mem_rdata[0] && (even_q != '0)) begin
						even_d = even_q - CW'(1);
					end
				end
			end
			S_SCAN: begin
				// data of the previous read is compared; stop on a hit or the last entry
				if (match || last_q) begin
					res_valid = 1'b1;
					r_found   = match;
					state_d   = S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = addr_q;
					addr_d    = addr_q + AW'(1);
					last_d    = (CW'(addr_q) == (count_q - CW'(1)));
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res.top_value  = r_top;
		res.status     = r_status;
		res.found      = r_found;
		res.depth_now  = lss_pkg::CNT_W'(count_d);
		res.even_count = lss_pkg::CNT_W'(even_d);
		res.odd_count  = lss_pkg::CNT_W'(count_d - even_d);
		res.is_empty   = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			even_q  <= '0;
			last_q  <= 1'b0;
			pop_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			even_q  <= even_d;
			last_q  <= last_d;
			pop_q   <= pop_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_d;
		addr_q <= addr_d;
	end

endmodule

`default_nettype wire

@@ rtl/lifo_stack_with_search.sv @@
// LIFO stack with search: top level; uses lss_pkg, lss_if, lss_mem, lss_ctrl.
// Command beat to result register: push or any rejected op writes the result
// register directly; pop/peek take one read of the entry store; search reads
// entries from the bottom up to the first hit, or the whole depth if none.
// One beat in flight: a new command is taken only once the last one has finished.
// Reset: arst_n clears depth, even count, sequencer and result valid; entries are not cleared.
`default_nettype none

module lifo_stack_with_search #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lss_cmd_if.sink    cmd,
	lss_res_if.source  res
);

	localparam int AW = $clog2(DEPTH);

	logic                      accept;
	logic                      ctrl_idle;
	logic                      res_valid;
	lss_pkg::res_t             res_d;
	lss_pkg::res_t             res_q;
	logic                      valid_q;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [lss_pkg::VAL_W-1:0] mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	logic [lss_pkg::VAL_W-1:0] mem_rdata;

	// Take a new command only with the sequencer idle and the result register
	// free by the next edge. Every op finishes into a free register, since the
	// only beat that could fill it is the one in flight.
	assign cmd.ready = ctrl_idle && (!valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;

	lss_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (cmd.op),
		.value     (cmd.value),
		.idle      (ctrl_idle),
		.res_valid (res_valid),
		.res       (res_d),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry store. Reads and writes never target the same entry in one cycle:
	// the sequencer runs one op at a time, and a pop after a push reads on a
	// later edge than the write.
	lss_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result register: holds a finished beat until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res_d;
		end
	end

	assign res.valid      = valid_q;
	assign res.top_value  = res_q.top_value;
	assign res.status     = res_q.status;
	assign res.found      = res_q.found;
	assign res.depth_now  = res_q.depth_now;
	assign res.even_count = res_q.even_count;
	assign res.odd_count  = res_q.odd_count;
	assign res.is_empty   = res_q.is_empty;

endmodule

`default_nettype wire

@@ rtl/lss_checker.sv @@
// Port-level checks on result beats of the LIFO stack, bound to the top level.
// Depends on lss_pkg and lifo_stack_with_search_macros.svh.
`default_nettype none
`include "lifo_stack_with_search_macros.svh"

module lss_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              res_valid,
	input wire logic                              res_ready,
	input wire logic signed [lss_pkg::VAL_W-1:0]  res_top_value,
	input wire logic [1:0]                        res_status,
	input wire logic                              res_found,
	input wire logic [lss_pkg::CNT_W-1:0]         res_depth_now,
	input wire logic [lss_pkg::CNT_W-1:0]         res_even_count,
	input wire logic [lss_pkg::CNT_W-1:0]         res_odd_count,
	input wire logic                              res_is_empty
);

	`LSS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_top_value) && $stable(res_status) && $stable(res_depth_now), "result beat changed while stalled")

	`LSS_ASSERT_IMP(a_counts_sum, res_valid, lss_pkg::CNT_W'(res_even_count + res_odd_count) == res_depth_now, "even plus odd count differs from depth")

	`LSS_ASSERT_IMP(a_empty_flag, res_valid && res_is_empty, res_depth_now == '0 && res_even_count == '0, "empty flag with entries left")

	`LSS_ASSERT_IMP(a_full_beat, res_valid && res_status == lss_pkg::ST_FULL, res_top_value == '0 && !res_found && !res_is_empty, "full beat carries data")

	`LSS_ASSERT_IMP(a_empty_beat, res_valid && res_status == lss_pkg::ST_EMPTY, res_is_empty && res_top_value == '0 && !res_found, "empty beat on a non-empty stack")

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_top_value  (res.top_value),
	.res_status     (res.status),
	.res_found      (res.found),
	.res_depth_now  (res.depth_now),
	.res_even_count (res.even_count),
	.res_odd_count  (res.odd_count),
	.res_is_empty   (res.is_empty)
);

`default_nettype wire

@@ tb/lifo_stack_with_search_tb.sv @@
// Self-checking bench for the LIFO stack with search: push, pop, peek and search beats
// checked against an in-bench stack tracker, under randomised stalls on both channels.
// Depends on lss_pkg, lss_if (lss_cmd_if, lss_res_if) and the lifo_stack_with_search RTL.

module lifo_stack_with_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lss_pkg::*;

	localparam int STACK_DEPTH  = DEPTH_DEF;
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int N_ITEMS      = 1150;
	localparam int QUIET_TAIL   = 150;            // last beats sent with no idling at all
	localparam int HOLD_AT      = 300;            // beat count that triggers the long stall
	localparam int HOLD_CYCLES  = 300;
	localparam int PAUSE_AT     = 600;            // beat count where the sender waits for drain
	localparam int MAX_REPORTS  = 10;
	localparam int SETTLE       = STACK_DEPTH + 16; // worst search latency plus margin
	localparam int TIMEOUT_NS   = 5_000_000;

	// Tracks the stack contents beat by beat and queues the result each command owes.
	class lifo_tracker;
		logic signed [VAL_W-1:0] cells[STACK_DEPTH];
		int unsigned             fill;
		int unsigned             evens;
		res_t                    due_results[$];
		int                      mismatches;
		int                      unexpected;
		int                      op_count[4];
		int                      full_hits;
		int                      empty_hits;
		int                      search_hits;
		int unsigned             deepest;

		function new();
			fill = 0;
			evens = 0;
			mismatches = 0;
			unexpected = 0;
			full_hits = 0;
			empty_hits = 0;
			search_hits = 0;
			deepest = 0;
			foreach (op_count[i]) op_count[i] = 0;
		endfunction

		function void predict_op(logic [1:0] op, logic signed [VAL_W-1:0] val);
			res_t want;
			int   i;
			want = '0;
			want.status = ST_OK;
			op_count[op]++;
			case (op)
				OP_PUSH: begin
					if (fill >= STACK_DEPTH) begin
						want.status = ST_FULL;
						full_hits++;
					end else begin
						cells[fill] = val;
						fill++;
						if (!val[0]) evens++;
					end
				end
				OP_POP, OP_PEEK: begin
					if (fill == 0) begin
						want.status = ST_EMPTY;
						empty_hits++;
					end else begin
						want.top_value = cells[fill-1];
						if (op == OP_POP) begin
							fill--;
							if (!want.top_value[0] && evens > 0) evens--;
						end
					end
				end
				default: begin
					for (i = 0; i < fill; i++)
						if (cells[i] == val) want.found = 1'b1;
					if (want.found) search_hits++;
				end
			endcase
			want.depth_now  = CNT_W'(fill);
			want.even_count = CNT_W'(evens);
			want.odd_count  = CNT_W'(fill - evens);
			want.is_empty   = (fill == 0);
			if (fill > deepest) deepest = fill;
			due_results.push_back(want);
		endfunction

		function string fmt(res_t r);
			return $sformatf("top=%0d st=%0d found=%0d depth=%0d even=%0d odd=%0d empty=%0d",
				r.top_value, r.status, r.found, r.depth_now, r.even_count, r.odd_count,
				r.is_empty);
		endfunction

		function void check_result(res_t got);
			res_t  want;
			string diff;
			if (due_results.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= MAX_REPORTS)
					$display("[%0t] result beat with nothing outstanding: %s", $realtime, fmt(got));
				return;
			end
			want = due_results.pop_front();
			diff = "";
			if (got.top_value  !== want.top_value)  diff = {diff, " top_value"};
			if (got.status     !== want.status)     diff = {diff, " status"};
			if (got.found      !== want.found)      diff = {diff, " found"};
			if (got.depth_now  !== want.depth_now)  diff = {diff, " depth_now"};
			if (got.even_count !== want.even_count) diff = {diff, " even_count"};
			if (got.odd_count  !== want.odd_count)  diff = {diff, " odd_count"};
			if (got.is_empty   !== want.is_empty)   diff = {diff, " is_empty"};
			if (diff != "") begin
				mismatches++;
				if (mismatches + unexpected <= MAX_REPORTS)
					$display("[%0t] mismatch in%s\n  expected %s\n  actual   %s",
						$realtime, diff, fmt(want), fmt(got));
			end
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function int failures();
			return mismatches + unexpected + due_results.size();
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	lss_cmd_if cmd_if ();
	lss_res_if res_if ();

	lifo_stack_with_search #(
		.DEPTH(STACK_DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.res   (res_if)
	);

	lifo_tracker stack_track = new();

	// Handshake between the stimulus and the receiver: one long stall request,
	// and a flag that switches idling off for the tail of the run.
	bit long_hold_go = 1'b0;
	bit no_gaps      = 1'b0;

	// Sender-side view of the stack, kept only to steer stimulus (search hits,
	// fill/drain phases). Updated when a beat is offered, not when accepted;
	// since beats are offered strictly in order the two never diverge.
	logic signed [VAL_W-1:0] track_cells[STACK_DEPTH];
	int unsigned             track_fill = 0;
	int                      issued     = 0;

	always #CLK_HALF clk = ~clk;

	// Watch both channels. Drivers use nonblocking updates at the edge, so what
	// is read here is the value that was stable before the edge.
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready)
				stack_track.predict_op(cmd_if.op, cmd_if.value);
			if (res_if.valid && res_if.ready) begin
				got.top_value  = res_if.top_value;
				got.status     = res_if.status;
				got.found      = res_if.found;
				got.depth_now  = res_if.depth_now;
				got.even_count = res_if.even_count;
				got.odd_count  = res_if.odd_count;
				got.is_empty   = res_if.is_empty;
				stack_track.check_result(got);
			end
		end
	end

	// Result receiver: mostly ready, short random stalls, one long hold-off that
	// it counts out itself while the sender keeps offering beats.
	initial begin
		res_if.ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold_go) begin
				long_hold_go = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Drop valid for an idle gap; the payload wanders meanwhile and must be ignored.
	task automatic idle_cmd(input int n);
		cmd_if.valid <= 1'b0;
		cmd_if.op    <= 2'($urandom);
		cmd_if.value <= $urandom;
		repeat (n) @(posedge clk);
	endtask

	// Offer one command beat and hold it until taken. Valid is never lowered
	// and raised in the same step: either the next beat or an idle follows.
	task automatic send_cmd(input logic [1:0] op, input logic signed [VAL_W-1:0] val);
		cmd_if.valid <= 1'b1;
		cmd_if.op    <= op;
		cmd_if.value <= val;
		if (op == OP_PUSH && track_fill < STACK_DEPTH) begin
			track_cells[track_fill] = val;
			track_fill++;
		end else if (op == OP_POP && track_fill > 0) begin
			track_fill--;
		end
		issued++;
		do @(posedge clk); while (!cmd_if.ready);
		if (!no_gaps && $urandom_range(0, 4) == 0)
			idle_cmd($urandom_range(1, 3));
	endtask

	// Values lean on the extremes and a small signed range so that duplicates,
	// parity flips and sign bits all turn up; the rest is full 32-bit noise.
	function automatic logic signed [VAL_W-1:0] pick_value();
		int s;
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2, 3: begin
				s = int'($urandom_range(0, 15)) - 8;
				return s;
			end
			default: return $urandom;
		endcase
	endfunction

	// Two in three searches aim at a stored entry, anywhere from bottom to top.
	function automatic logic signed [VAL_W-1:0] search_value();
		if (track_fill > 0 && $urandom_range(0, 2) != 0)
			return track_cells[$urandom_range(0, track_fill - 1)];
		return pick_value();
	endfunction

	// One weighted random command, plus the pressure hooks keyed to beat count.
	task automatic random_op(input int w_push, input int w_pop, input int w_peek,
		input int w_search);
		int r;
		r = $urandom_range(0, w_push + w_pop + w_peek + w_search - 1);
		if (r < w_push)
			send_cmd(OP_PUSH, pick_value());
		else if (r < w_push + w_pop)
			send_cmd(OP_POP, $urandom);
		else if (r < w_push + w_pop + w_peek)
			send_cmd(OP_PEEK, $urandom);
		else
			send_cmd(OP_SEARCH, search_value());

		if (issued == HOLD_AT)
			long_hold_go = 1'b1;
		if (issued == PAUSE_AT) begin
			// sender goes quiet until every owed result is back
			idle_cmd(1);
			while (stack_track.outstanding() != 0) @(posedge clk);
		end
		if (issued >= N_ITEMS - QUIET_TAIL)
			no_gaps = 1'b1;
	endtask

	initial begin
		cmd_if.valid = 1'b0;
		cmd_if.op    = OP_PUSH;
		cmd_if.value = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-stack flags, signed extremes, parity of negatives,
		// search hit at the bottom and a miss, drain past empty.
		send_cmd(OP_POP, 0);
		send_cmd(OP_PEEK, 0);
		send_cmd(OP_SEARCH, 0);
		send_cmd(OP_PUSH, 32'sh8000_0000);
		send_cmd(OP_PUSH, 32'sh7fff_ffff);
		send_cmd(OP_PUSH, 0);
		send_cmd(OP_PUSH, -1);
		send_cmd(OP_PUSH, -2);
		send_cmd(OP_PEEK, 0);
		send_cmd(OP_SEARCH, 32'sh8000_0000);
		send_cmd(OP_SEARCH, 32'sh7fff_ffff);
		send_cmd(OP_SEARCH, -1);
		send_cmd(OP_SEARCH, 12345);
		repeat (5) send_cmd(OP_POP, 0);
		send_cmd(OP_POP, 0);
		send_cmd(OP_PEEK, 0);
		send_cmd(OP_SEARCH, -2);
		send_cmd(OP_PUSH, 1);
		send_cmd(OP_POP, 0);

		// Random phases: fill to the top and push past it, drain to empty and
		// pop past it, or a free mix. Searches are spread through all of them.
		while (issued < N_ITEMS) begin
			case ($urandom_range(0, 2))
				0: begin
					while (track_fill < STACK_DEPTH && issued < N_ITEMS)
						random_op(17, 1, 1, 2);
					repeat ($urandom_range(1, 4)) random_op(4, 0, 0, 1);
				end
				1: begin
					while (track_fill > 0 && issued < N_ITEMS)
						random_op(1, 14, 2, 3);
					repeat ($urandom_range(1, 3)) random_op(0, 2, 1, 1);
				end
				default: begin
					repeat ($urandom_range(10, 60)) random_op(4, 3, 2, 3);
				end
			endcase
		end

		idle_cmd(0);
		while (stack_track.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d commands: %0d push, %0d pop, %0d peek, %0d search; depth reached %0d.",
			issued, stack_track.op_count[OP_PUSH], stack_track.op_count[OP_POP],
			stack_track.op_count[OP_PEEK], stack_track.op_count[OP_SEARCH], stack_track.deepest);
		$display("Pushes refused on full %0d, pop/peek on empty %0d, search hits %0d, failures %0d.",
			stack_track.full_hits, stack_track.empty_hits, stack_track.search_hits,
			stack_track.failures());
		if (stack_track.failures() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog, set far beyond the slowest legal run (full-depth misses on
	// every beat, maximum stalls on both sides and the long hold-off).
	initial begin
		#(TIMEOUT_NS);
		$display("Watchdog expired with %0d results still owed.", stack_track.outstanding());
		$display("TB_ERROR");
		$finish;
	end

endmodule
